// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression never holds out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== hw/rtl/efp_pkg.sv =====
// ---------------------------------------------------------------------------
// Escape-time fractal pixel package
// Types, codes and constants shared by the pixel unit.
// ---------------------------------------------------------------------------
package efp_pkg;

	localparam int MUL_W  = 38;
	localparam int PROD_W = 2 * MUL_W;
	localparam int RAD_W  = 40;
	localparam int ROOT_W = 20;
	localparam int SUM_W  = 28;
	localparam int CNT_W  = 12;
	localparam int NTERMS = 12;

	localparam logic [30:0] EXP_NEG1_Q32 = 31'd1580030169;
	localparam logic [15:0] WRAP_Q16     = 16'd64881;

	localparam logic [1:0] MODE_MANDEL = 2'd0;
	localparam logic [1:0] MODE_JULIA  = 2'd1;
	localparam logic [1:0] MODE_SHIP   = 2'd2;
	localparam logic [1:0] MODE_ALT    = 2'd3;

	typedef enum logic [2:0] {
		CFG_CORNER_RE  = 3'd0,
		CFG_CORNER_IM  = 3'd1,
		CFG_PITCH      = 3'd2,
		CFG_MAX_ITER   = 3'd3,
		CFG_MODE       = 3'd4,
		CFG_JULIA_RE   = 3'd5,
		CFG_JULIA_IM   = 3'd6,
		CFG_HUE_OFFSET = 3'd7
	} cfg_idx_e;

	typedef enum logic [4:0] {
		S_IDLE, S_PX, S_PY, S_Y0, S_SQX, S_SQY, S_XY, S_CHK, S_ROOT,
		S_TM, S_TD, S_TQ, S_CLAMP, S_SC, S_SCW, S_ACC, S_DIV_GO, S_DIV_WAIT
	} state_e;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
	} req_t;

	typedef struct packed {
		logic signed [23:0] hue;
		logic        [10:0] iterations;
		logic               escaped;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] corner_re;
		logic signed [31:0] corner_im;
		logic        [30:0] pixel_pitch;
		logic        [10:0] lim;
		logic        [1:0]  mode;
		logic signed [31:0] julia_re;
		logic signed [31:0] julia_im;
		logic signed [23:0] hue_offset;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh000000007FFFFFFF)
			return 32'sh7FFFFFFF;
		else if (v < 64'shFFFFFFFF80000000)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// ceil(2^36 / k); exact floor quotient for 32-bit dividends and k up to 12
	function automatic logic [36:0] recip(input logic [3:0] k);
		case (k)
			4'd1:    return 37'd68719476736;
			4'd2:    return 37'd34359738368;
			4'd3:    return 37'd22906492246;
			4'd4:    return 37'd17179869184;
			4'd5:    return 37'd13743895348;
			4'd6:    return 37'd11453246123;
			4'd7:    return 37'd9817068106;
			4'd8:    return 37'd8589934592;
			4'd9:    return 37'd7635497416;
			4'd10:   return 37'd6871947674;
			4'd11:   return 37'd6247225158;
			4'd12:   return 37'd5726623062;
			default: return 37'd0;
		endcase
	endfunction

endpackage

// ===== hw/rtl/efp_mult.sv =====
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, shared by the multiplying steps of the sequencer.
// ---------------------------------------------------------------------------
module efp_mult (
	input  logic                                 clk,
	input  logic signed [efp_pkg::MUL_W-1:0]     a,
	input  logic signed [efp_pkg::MUL_W-1:0]     b,
	output logic signed [efp_pkg::PROD_W-1:0]    p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== hw/rtl/efp_isqrt.sv =====
// ---------------------------------------------------------------------------
// Integer square root
// Floor square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module efp_isqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [efp_pkg::RAD_W-1:0]          radicand,
	output logic [efp_pkg::ROOT_W-1:0]         root,
	output logic                               done
);

	localparam int CW = $clog2(efp_pkg::ROOT_W + 1);

	logic [CW-1:0]                  cnt_q;
	logic                           done_q;
	logic [efp_pkg::RAD_W-1:0]      rad_q;
	logic [efp_pkg::ROOT_W:0]       rem_q;
	logic [efp_pkg::ROOT_W-1:0]     root_q;
	logic [efp_pkg::ROOT_W+2:0]     trial_rem;
	logic [efp_pkg::ROOT_W+2:0]     trial;
	logic [efp_pkg::ROOT_W+2:0]     diff;
	logic                           ge;

	assign trial_rem = {rem_q, rad_q[efp_pkg::RAD_W-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign ge        = trial_rem >= trial;
	assign diff      = trial_rem - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(efp_pkg::ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[efp_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[efp_pkg::ROOT_W:0] : trial_rem[efp_pkg::ROOT_W:0];
			root_q <= {root_q[efp_pkg::ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/efp_div.sv =====
// ---------------------------------------------------------------------------
// Hue divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module efp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [efp_pkg::SUM_W-1:0]       dividend,
	input  logic [10:0]                     divisor,
	output logic [efp_pkg::SUM_W-1:0]       quotient,
	output logic                            done
);

	localparam int CW = $clog2(efp_pkg::SUM_W + 1);

	logic [CW-1:0]                cnt_q;
	logic                         done_q;
	logic [efp_pkg::SUM_W-1:0]    dvd_q;
	logic [10:0]                  rem_q;
	logic [10:0]                  dsr_q;
	logic [11:0]                  trial;
	logic [11:0]                  diff;
	logic                         ge;

	assign trial = {rem_q, dvd_q[efp_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(efp_pkg::SUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[efp_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? diff[10:0] : trial[10:0];
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/efp_seq.sv =====
// ---------------------------------------------------------------------------
// Pixel sequencer
// Steps the shared multiplier, root and divider units through one pixel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module efp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  efp_pkg::req_t   req,
	input  efp_pkg::cfg_t   cfg,
	output logic            busy,
	output logic            done,
	output efp_pkg::rsp_t   rsp
);

	efp_pkg::state_e state_q, state_d;

	logic [9:0]                      px_q, py_q;
	logic [10:0]                     lim_q;
	logic [efp_pkg::CNT_W-1:0]       count_q;
	logic                            first_q, esc_q, done_q;
	logic signed [31:0]              x_q, y_q, cx_q, cy_q, nx_q, ny_q;
	logic signed [63:0]              xx_q, yy_q;
	logic [3:0]                      n_q, k_q;
	logic [15:0]                     f_q;
	logic [32:0]                     term_q, vv_q;
	logic signed [34:0]              esum_q;
	logic signed [efp_pkg::SUM_W-1:0] sum_q;
	efp_pkg::rsp_t                   rsp_q;

	logic signed [efp_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [efp_pkg::PROD_W-1:0] mul_p;
	logic                              sqrt_start, sqrt_done;
	logic [efp_pkg::ROOT_W-1:0]        root;
	logic                              div_start, div_done;
	logic [efp_pkg::SUM_W-1:0]         div_quo, sum_mag;
	logic [10:0]                       div_dsr;

	logic [63:0]        m2;
	logic               over, esc_now, big, julia, ship;
	logic signed [63:0] xy, d64, p64, pabs, cx64, cy64, nx64, ny64, x64, y64;
	logic signed [31:0] x0, y0;
	logic [31:0]        q32;
	logic [64:0]        vsc;
	logic [16:0]        e17;
	logic signed [efp_pkg::SUM_W-1:0] e28, off28;
	logic signed [28:0] t_raw;
	logic signed [29:0] t_wr;
	logic signed [23:0] hue;

	efp_mult u_mult (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	efp_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand(m2[57:18]), .root(root), .done(sqrt_done)
	);

	efp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_mag), .divisor(div_dsr), .quotient(div_quo), .done(div_done)
	);

	assign julia   = (cfg.mode == efp_pkg::MODE_JULIA) || (cfg.mode == efp_pkg::MODE_ALT);
	assign ship    = cfg.mode == efp_pkg::MODE_SHIP;
	assign m2      = xx_q + yy_q;
	assign over    = count_q > {1'b0, lim_q};
	assign esc_now = |m2[63:54];
	assign big     = |m2[63:58];
	assign xy      = mul_p[63:0];
	assign d64     = (xx_q - yy_q) >>> 25;
	assign p64     = xy >>> 24;
	assign pabs    = p64[63] ? -p64 : p64;
	assign cx64    = {{32{cx_q[31]}}, cx_q};
	assign cy64    = {{32{cy_q[31]}}, cy_q};
	assign nx64    = ship ? d64 - cx64 : d64 + cx64;
	assign ny64    = ship ? -pabs - cy64 : p64 + cy64;
	assign x64     = {{32{cfg.corner_re[31]}}, cfg.corner_re} + $signed({23'b0, mul_p[40:0]});
	assign y64     = {{32{cfg.corner_im[31]}}, cfg.corner_im} + $signed({23'b0, mul_p[40:0]});
	assign x0      = efp_pkg::sat32(x64);
	assign y0      = efp_pkg::sat32(y64);
	assign q32     = mul_p[67:36];
	assign vsc     = mul_p[64:0] + 65'h80000000;
	assign e17     = 17'(({1'b0, vv_q} + 34'd32768) >> 16);
	assign e28     = {{(efp_pkg::SUM_W-17){1'b0}}, e17};
	assign off28   = {{(efp_pkg::SUM_W-24){cfg.hue_offset[23]}}, cfg.hue_offset};
	assign sum_mag = sum_q[efp_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign div_dsr = (lim_q == '0) ? 11'd1 : lim_q;

	always_comb begin
		t_raw = sum_q[efp_pkg::SUM_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		if (t_raw >= 29'sd65536)
			t_wr = {t_raw[28], t_raw} - 30'sd64881;
		else if (t_raw <= 29'sd0)
			t_wr = {t_raw[28], t_raw} + 30'sd64881;
		else
			t_wr = {t_raw[28], t_raw};
		if (t_wr > 30'sd8388607)
			hue = 24'sh7FFFFF;
		else if (t_wr < -30'sd8388608)
			hue = 24'sh800000;
		else
			hue = t_wr[23:0];
	end

	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			efp_pkg::S_IDLE: begin
				if (go)
					state_d = efp_pkg::S_PX;
			end
			efp_pkg::S_PX: begin
				mul_a   = {28'b0, px_q};
				mul_b   = {7'b0, cfg.pixel_pitch};
				state_d = efp_pkg::S_PY;
			end
			efp_pkg::S_PY: begin
				mul_a   = {28'b0, py_q};
				mul_b   = {7'b0, cfg.pixel_pitch};
				state_d = efp_pkg::S_Y0;
			end
			efp_pkg::S_Y0, efp_pkg::S_SQX: begin
				mul_a   = {{6{x_q[31]}}, x_q};
				mul_b   = {{6{x_q[31]}}, x_q};
				state_d = efp_pkg::S_SQY;
			end
			efp_pkg::S_SQY: begin
				mul_a   = {{6{y_q[31]}}, y_q};
				mul_b   = {{6{y_q[31]}}, y_q};
				state_d = efp_pkg::S_XY;
			end
			efp_pkg::S_XY: begin
				mul_a   = {{6{x_q[31]}}, x_q};
				mul_b   = {{6{y_q[31]}}, y_q};
				state_d = efp_pkg::S_CHK;
			end
			efp_pkg::S_CHK: begin
				if (over || (esc_now && !first_q)) begin
					state_d = efp_pkg::S_DIV_GO;
				end else if (big) begin
					state_d = efp_pkg::S_ACC;
				end else begin
					sqrt_start = 1'b1;
					state_d    = efp_pkg::S_ROOT;
				end
			end
			efp_pkg::S_ROOT: begin
				if (sqrt_done)
					state_d = efp_pkg::S_TM;
			end
			efp_pkg::S_TM: begin
				mul_a   = {5'b0, term_q};
				mul_b   = {22'b0, f_q};
				state_d = efp_pkg::S_TD;
			end
			efp_pkg::S_TD: begin
				mul_a   = {6'b0, mul_p[47:16]};
				mul_b   = {1'b0, efp_pkg::recip(k_q)};
				state_d = efp_pkg::S_TQ;
			end
			efp_pkg::S_TQ: begin
				state_d = (k_q == 4'(efp_pkg::NTERMS)) ? efp_pkg::S_CLAMP : efp_pkg::S_TM;
			end
			efp_pkg::S_CLAMP: begin
				state_d = (n_q == '0) ? efp_pkg::S_ACC : efp_pkg::S_SC;
			end
			efp_pkg::S_SC: begin
				mul_a   = {5'b0, vv_q};
				mul_b   = {7'b0, efp_pkg::EXP_NEG1_Q32};
				state_d = efp_pkg::S_SCW;
			end
			efp_pkg::S_SCW: begin
				state_d = (n_q == 4'd1) ? efp_pkg::S_ACC : efp_pkg::S_SC;
			end
			efp_pkg::S_ACC: begin
				state_d = esc_q ? efp_pkg::S_DIV_GO : efp_pkg::S_SQX;
			end
			efp_pkg::S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = efp_pkg::S_DIV_WAIT;
			end
			efp_pkg::S_DIV_WAIT: begin
				if (div_done)
					state_d = efp_pkg::S_IDLE;
			end
			default: state_d = efp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efp_pkg::S_IDLE;
			count_q <= '0;
			lim_q   <= '0;
			first_q <= 1'b0;
			esc_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == efp_pkg::S_DIV_WAIT) && div_done;
			case (state_q)
				efp_pkg::S_IDLE: begin
					if (go) begin
						count_q <= '0;
						lim_q   <= cfg.lim;
						first_q <= 1'b1;
						esc_q   <= 1'b0;
					end
				end
				efp_pkg::S_CHK: begin
					if (!over)
						esc_q <= esc_now;
				end
				efp_pkg::S_ACC: begin
					if (!esc_q) begin
						count_q <= count_q + 1'b1;
						first_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			efp_pkg::S_IDLE: begin
				px_q <= req.pixel_x;
				py_q <= req.pixel_y;
			end
			efp_pkg::S_PY: begin
				x_q  <= x0;
				cx_q <= julia ? cfg.julia_re : x0;
			end
			efp_pkg::S_Y0: begin
				y_q  <= y0;
				cy_q <= julia ? cfg.julia_im : y0;
			end
			efp_pkg::S_SQY: xx_q <= mul_p[63:0];
			efp_pkg::S_XY:  yy_q <= mul_p[63:0];
			efp_pkg::S_CHK: begin
				nx_q <= efp_pkg::sat32(nx64);
				ny_q <= efp_pkg::sat32(ny64);
				vv_q <= '0;
			end
			efp_pkg::S_ROOT: begin
				n_q    <= root[efp_pkg::ROOT_W-1 -: 4];
				f_q    <= root[15:0];
				term_q <= 33'h100000000;
				esum_q <= 35'sh100000000;
				k_q    <= 4'd1;
			end
			efp_pkg::S_TQ: begin
				term_q <= {1'b0, q32};
				esum_q <= k_q[0] ? esum_q - $signed({3'b0, q32}) : esum_q + $signed({3'b0, q32});
				k_q    <= k_q + 4'd1;
			end
			efp_pkg::S_CLAMP: vv_q <= esum_q[34] ? 33'd0 : esum_q[32:0];
			efp_pkg::S_SCW: begin
				vv_q <= vsc[64:32];
				n_q  <= n_q - 4'd1;
			end
			efp_pkg::S_ACC: begin
				if (first_q)
					sum_q <= e28 + off28 + (esc_q ? '0 : e28);
				else
					sum_q <= sum_q + e28;
				if (!esc_q) begin
					x_q <= nx_q;
					y_q <= ny_q;
				end
			end
			efp_pkg::S_DIV_WAIT: begin
				rsp_q.hue        <= hue;
				rsp_q.iterations <= count_q[10:0];
				rsp_q.escaped    <= esc_q;
			end
			default: ;
		endcase
	end

	assign busy = state_q != efp_pkg::S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= ({1'b0, lim_q} + 12'd1), "pass count beyond limit")
	`ASSERT_CLK(a_esc_first, clk, arst_n, (state_q == efp_pkg::S_ACC && esc_q) |-> first_q, "escaped pass accumulated late")
	`ASSERT_CLK(a_done_div, clk, arst_n, done_q |-> $past(div_done), "result without division")
	`ASSERT_NEVER(a_done_idle, clk, arst_n, done_q && state_q != efp_pkg::S_IDLE, "result while busy")

endmodule

// ===== hw/rtl/escape_time_fractal_pixel_unit.sv =====
// ---------------------------------------------------------------------------
// Escape-time fractal pixel unit
// Maps a pixel to a complex point, iterates it and returns a hue, pass count and escape flag.
// ---------------------------------------------------------------------------
// A request (pixel_x, pixel_y) is taken at a clock edge with start high and
// busy low. busy stays high until the result is delivered; done is high for
// exactly one cycle with hue, iterations and escaped on rsp. The receiver
// cannot hold a result off, so nothing waits on it.
// Each request runs setup, then passes of squaring and check, square
// root, series, one scaling step per whole unit of |z| (up to 15) and
// accumulation, with root, series and scaling skipped once |z| reaches
// 16; a final check and the division follow. Passes run up to
// min(max_iter, ITER_LIMIT) + 1 times. One multiplier, one root unit and
// one divider serve the steps in turn, and one pixel is in flight at a time.
// Configuration goes through cfg_we/cfg_addr/cfg_wdata; the user must write
// it only while idle, which the block does not enforce. Reset clears the
// sequencer and loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module escape_time_fractal_pixel_unit #(
	parameter int SCREEN_SIZE = 1024,
	parameter int ITER_LIMIT  = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  efp_pkg::req_t   req,
	output logic            done,
	output efp_pkg::rsp_t   rsp,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_addr,
	input  logic [31:0]     cfg_wdata
);

	logic signed [31:0] corner_re_q, corner_im_q, julia_re_q, julia_im_q;
	logic        [30:0] pitch_q;
	logic        [10:0] max_iter_q;
	logic        [1:0]  mode_q;
	logic signed [23:0] hue_offset_q;

	efp_pkg::cfg_t cfg;
	efp_pkg::req_t req_c;
	logic          go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_re_q  <= 32'shFC000000;
			corner_im_q  <= 32'shFC000000;
			pitch_q      <= 31'd131072;
			max_iter_q   <= 11'd50;
			mode_q       <= efp_pkg::MODE_MANDEL;
			julia_re_q   <= '0;
			julia_im_q   <= '0;
			hue_offset_q <= '0;
		end else if (cfg_we) begin
			case (efp_pkg::cfg_idx_e'(cfg_addr))
				efp_pkg::CFG_CORNER_RE:  corner_re_q  <= cfg_wdata;
				efp_pkg::CFG_CORNER_IM:  corner_im_q  <= cfg_wdata;
				efp_pkg::CFG_PITCH:      pitch_q      <= cfg_wdata[30:0];
				efp_pkg::CFG_MAX_ITER:   max_iter_q   <= cfg_wdata[10:0];
				efp_pkg::CFG_MODE:       mode_q       <= cfg_wdata[1:0];
				efp_pkg::CFG_JULIA_RE:   julia_re_q   <= cfg_wdata;
				efp_pkg::CFG_JULIA_IM:   julia_im_q   <= cfg_wdata;
				efp_pkg::CFG_HUE_OFFSET: hue_offset_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.corner_re   = corner_re_q;
		cfg.corner_im   = corner_im_q;
		cfg.pixel_pitch = pitch_q;
		cfg.mode        = mode_q;
		cfg.julia_re    = julia_re_q;
		cfg.julia_im    = julia_im_q;
		cfg.hue_offset  = hue_offset_q;
		if (int'(max_iter_q) > ITER_LIMIT)
			cfg.lim = 11'(ITER_LIMIT);
		else
			cfg.lim = max_iter_q;
		req_c = req;
		if (int'(req.pixel_x) > SCREEN_SIZE - 1)
			req_c.pixel_x = 10'(SCREEN_SIZE - 1);
		if (int'(req.pixel_y) > SCREEN_SIZE - 1)
			req_c.pixel_y = 10'(SCREEN_SIZE - 1);
	end

	assign go = start && !busy;

	efp_seq u_seq (
		.clk(clk), .arst_n(arst_n), .go(go), .req(req_c), .cfg(cfg),
		.busy(busy), .done(done), .rsp(rsp)
	);

endmodule

// ===== test/escape_time_fractal_pixel_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Escape-time fractal pixel checker
// Watches the request, result and register ports of the pixel unit. It keeps
// its own copy of the registers, predicts hue, pass count and escape flag for
// every accepted request, and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
module escape_time_fractal_pixel_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  efp_pkg::req_t   req,
	input  logic            done,
	input  efp_pkg::rsp_t   rsp,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_addr,
	input  logic [31:0]     cfg_wdata,
	output int              errors,
	output int              pending,
	output int              results_seen,
	output int              escapes_seen
);

	localparam int SCREEN_MAX = 1023;
	localparam int PASS_CAP   = 1024;
	localparam longint unsigned ESCAPE_Q50 = 64'd16 << 50;

	logic signed [31:0] corner_re, corner_im, julia_re, julia_im;
	logic        [30:0] pixel_pitch;
	logic        [10:0] max_iter;
	logic        [1:0]  mode;
	logic signed [23:0] hue_offset;

	efp_pkg::rsp_t expected_pixels[$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag_sq(longint x, longint y);
		return longint'(x * x) + longint'(y * y);
	endfunction

	function automatic longint decay_q16(longint unsigned m2);
		longint unsigned r, n, f, term, v;
		longint acc;
		r = root_floor(m2 >> 18);
		n = r >> 16;
		f = r & 64'hFFFF;
		term = 64'd1 << 32;
		acc = 64'sd1 <<< 32;
		if (n >= 16)
			return 0;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * f) >> 16) / k;
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		v = acc;
		repeat (n)
			v = (v * efp_pkg::EXP_NEG1_Q32 + (64'd1 << 31)) >> 32;
		return longint'((v + 64'd32768) >> 16);
	endfunction

	function automatic efp_pkg::rsp_t escape_pixel(efp_pkg::req_t r);
		efp_pkg::rsp_t o;
		longint px, py, lim, count, x, y, cx, cy, sum, t, d, p, nx, ny;
		longint unsigned m2;
		bit esc;
		px = r.pixel_x;
		py = r.pixel_y;
		if (px > SCREEN_MAX) px = SCREEN_MAX;
		if (py > SCREEN_MAX) py = SCREEN_MAX;
		lim = max_iter;
		if (lim > PASS_CAP) lim = PASS_CAP;
		count = 0;
		esc = 0;
		x = clamp32(longint'(corner_re) + px * longint'(pixel_pitch));
		y = clamp32(longint'(corner_im) + py * longint'(pixel_pitch));
		if (mode == efp_pkg::MODE_JULIA || mode == efp_pkg::MODE_ALT) begin
			cx = julia_re;
			cy = julia_im;
		end else begin
			cx = x;
			cy = y;
		end
		sum = decay_q16(mag_sq(x, y)) + longint'(hue_offset);
		while (count <= lim) begin
			m2 = mag_sq(x, y);
			if (m2 >= ESCAPE_Q50) begin
				esc = 1;
				break;
			end
			d = shr_floor(x * x - y * y, 25);
			p = shr_floor(x * y, 24);
			if (mode == efp_pkg::MODE_SHIP) begin
				if (p < 0) p = -p;
				nx = clamp32(d - cx);
				ny = clamp32(-p - cy);
			end else begin
				nx = clamp32(d + cx);
				ny = clamp32(p + cy);
			end
			sum = sum + decay_q16(m2);
			x = nx;
			y = ny;
			count++;
		end
		t = sum / ((lim == 0) ? 64'sd1 : lim);
		if (t >= 65536)
			t = t - longint'(efp_pkg::WRAP_Q16);
		else if (t <= 0)
			t = t + longint'(efp_pkg::WRAP_Q16);
		if (t > 8388607) t = 8388607;
		if (t < -8388608) t = -8388608;
		o.hue = t[23:0];
		o.iterations = count[10:0];
		o.escaped = esc;
		return o;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
		escapes_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_re <= -32'sd67108864;
			corner_im <= -32'sd67108864;
			pixel_pitch <= 31'd131072;
			max_iter <= 11'd50;
			mode <= efp_pkg::MODE_MANDEL;
			julia_re <= '0;
			julia_im <= '0;
			hue_offset <= '0;
		end else if (cfg_we) begin
			case (efp_pkg::cfg_idx_e'(cfg_addr))
				efp_pkg::CFG_CORNER_RE:  corner_re <= cfg_wdata;
				efp_pkg::CFG_CORNER_IM:  corner_im <= cfg_wdata;
				efp_pkg::CFG_PITCH:      pixel_pitch <= cfg_wdata[30:0];
				efp_pkg::CFG_MAX_ITER:   max_iter <= cfg_wdata[10:0];
				efp_pkg::CFG_MODE:       mode <= cfg_wdata[1:0];
				efp_pkg::CFG_JULIA_RE:   julia_re <= cfg_wdata;
				efp_pkg::CFG_JULIA_IM:   julia_im <= cfg_wdata;
				efp_pkg::CFG_HUE_OFFSET: hue_offset <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		efp_pkg::rsp_t want;
		if (arst_n) begin
			if (start && !busy)
				expected_pixels.push_back(escape_pixel(req));
			if (done) begin
				results_seen++;
				if (rsp.escaped)
					escapes_seen++;
				if (expected_pixels.size() == 0) begin
					report("unexpected result, hue", rsp.hue, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (rsp.hue !== want.hue)
						report("hue", rsp.hue, want.hue);
					if (rsp.iterations !== want.iterations)
						report("iterations", rsp.iterations, want.iterations);
					if (rsp.escaped !== want.escaped)
						report("escaped", rsp.escaped, want.escaped);
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// ===== test/escape_time_fractal_pixel_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Escape-time fractal pixel unit testbench
// Drives pixel requests and register settings into the unit: a directed set
// for corners, saturation, limit clamping and the MANDEL, ALT and SHIP
// modes, then random settings with random pixels and random gaps. A checker
// beside the unit predicts and compares every result.
// ---------------------------------------------------------------------------
module escape_time_fractal_pixel_unit_tb;

	localparam longint CYCLE_LIMIT = 4000000;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	efp_pkg::req_t   req;
	logic            done;
	efp_pkg::rsp_t   rsp;
	logic            cfg_we;
	logic [2:0]      cfg_addr;
	logic [31:0]     cfg_wdata;
	int              errors, pending, results_seen, escapes_seen;
	int              pixels_sent, settings_used;
	longint          cycles;
	bit              no_gaps;

	escape_time_fractal_pixel_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	escape_time_fractal_pixel_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .errors(errors), .pending(pending),
		.results_seen(results_seen), .escapes_seen(escapes_seen)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(efp_pkg::cfg_idx_e idx, logic [31:0] value);
		cfg_we = 1;
		cfg_addr = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic send_pixel(int px, int py);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		start = 1;
		req.pixel_x = 10'(px);
		req.pixel_y = 10'(py);
		while (busy)
			@(negedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic drain();
		start = 0;
		while (pending != 0)
			@(negedge clk);
		settings_used++;
	endtask

	task automatic random_settings();
		bit wild;
		wild = ($urandom_range(0, 3) == 0);
		if (wild) begin
			write_reg(efp_pkg::CFG_CORNER_RE, $urandom);
			write_reg(efp_pkg::CFG_CORNER_IM, $urandom);
			write_reg(efp_pkg::CFG_PITCH, $urandom);
			write_reg(efp_pkg::CFG_HUE_OFFSET, $urandom);
		end else begin
			write_reg(efp_pkg::CFG_CORNER_RE, -$urandom_range(0, 32'd83886080));
			write_reg(efp_pkg::CFG_CORNER_IM, -$urandom_range(0, 32'd67108864));
			write_reg(efp_pkg::CFG_PITCH, $urandom_range(0, 32'd262144));
			write_reg(efp_pkg::CFG_HUE_OFFSET, $urandom_range(0, 32'd131072) - 32'd65536);
		end
		write_reg(efp_pkg::CFG_MAX_ITER,
			($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 24));
		write_reg(efp_pkg::CFG_MODE, $urandom_range(0, 3));
		write_reg(efp_pkg::CFG_JULIA_RE,
			wild ? $urandom : $urandom_range(0, 32'd67108864) - 32'd33554432);
		write_reg(efp_pkg::CFG_JULIA_IM,
			wild ? $urandom : $urandom_range(0, 32'd67108864) - 32'd33554432);
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		req = '0;
		cfg_we = 0;
		cfg_addr = efp_pkg::CFG_CORNER_RE;
		cfg_wdata = '0;
		pixels_sent = 0;
		settings_used = 0;
		no_gaps = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(0, 1023);
		send_pixel(1023, 0);
		send_pixel(512, 512);
		send_pixel(341, 682);
		send_pixel(700, 300);
		drain();

		write_reg(efp_pkg::CFG_MAX_ITER, 32'd0);
		write_reg(efp_pkg::CFG_MODE, 32'(efp_pkg::MODE_ALT));
		write_reg(efp_pkg::CFG_JULIA_RE, -32'sd26843546);
		write_reg(efp_pkg::CFG_JULIA_IM, 32'sd5234491);
		write_reg(efp_pkg::CFG_HUE_OFFSET, 32'sd8388607);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(512, 512);
		drain();

		write_reg(efp_pkg::CFG_CORNER_RE, 32'sh7FFFFFFF);
		write_reg(efp_pkg::CFG_CORNER_IM, 32'sh80000000);
		write_reg(efp_pkg::CFG_PITCH, 32'h7FFFFFFF);
		write_reg(efp_pkg::CFG_MODE, 32'(efp_pkg::MODE_SHIP));
		write_reg(efp_pkg::CFG_MAX_ITER, 32'd1);
		write_reg(efp_pkg::CFG_HUE_OFFSET, -32'sd8388608);
		no_gaps = 1;
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(1, 0);
		send_pixel(0, 1);
		drain();

		write_reg(efp_pkg::CFG_PITCH, 32'd0);
		write_reg(efp_pkg::CFG_CORNER_RE, -32'sd16777216);
		write_reg(efp_pkg::CFG_CORNER_IM, 32'd0);
		write_reg(efp_pkg::CFG_MODE, 32'(efp_pkg::MODE_MANDEL));
		write_reg(efp_pkg::CFG_MAX_ITER, 32'd2047);
		write_reg(efp_pkg::CFG_HUE_OFFSET, 32'd0);
		send_pixel(5, 5);
		drain();
		write_reg(efp_pkg::CFG_MAX_ITER, 32'd1024);
		write_reg(efp_pkg::CFG_CORNER_RE, 32'd0);
		send_pixel(1023, 0);
		drain();

		no_gaps = 0;
		write_reg(efp_pkg::CFG_MODE, 32'(efp_pkg::MODE_SHIP));
		write_reg(efp_pkg::CFG_MAX_ITER, 32'd20);
		write_reg(efp_pkg::CFG_CORNER_RE, -32'sd67108864);
		write_reg(efp_pkg::CFG_CORNER_IM, -32'sd67108864);
		write_reg(efp_pkg::CFG_PITCH, 32'd131072);
		send_pixel(400, 450);
		send_pixel(200, 100);
		send_pixel(768, 256);
		drain();

		repeat (8) begin
			random_settings();
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (15)
				send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
			drain();
		end

		repeat (200) @(negedge clk);
		$display("covered %0d pixels under %0d register settings", pixels_sent, settings_used);
		$display("%0d results seen, %0d of them escaped", results_seen, escapes_seen);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
